FILE: hw/rtl/ehw_pkg.sv
// ----------------------------------------------------------------------------
// ehw_pkg: shared types, constants and helpers for the hue wheel color unit
// Hue arithmetic is kept modulo 360; colors come from six 60-degree sectors.
// ----------------------------------------------------------------------------
package ehw_pkg;

  // Register map of the configuration port
  localparam logic [1:0] REG_HUE_STEP  = 2'd0;
  localparam logic [1:0] REG_COOLDOWN  = 2'd1;
  localparam logic [1:0] REG_HAPTIC_EN = 2'd2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Field widths
  localparam int POS_W  = 32;
  localparam int TIME_W = 32;
  localparam int HUE_W  = 9;
  localparam int STEP_W = 9;
  localparam int COOL_W = 16;
  localparam int COL_W  = 8;

  // Reset values of the registers
  localparam int HUE_STEP_RST = 5;
  localparam int COOLDOWN_RST = 200;

  // Modulo-360 arithmetic
  localparam int HUE_MOD   = 360;
  localparam int FOLD_W    = 17;         // byte-folded position, < 2^17
  localparam int SUM_W     = 18;         // base + W*step, < 2^18
  localparam int RECIP_M   = 93207;      // ceil(2^25 / 360)
  localparam int RECIP_SH  = 25;
  localparam int FOLD_B3   = 136;        // 2^24 mod 360
  localparam int FOLD_B2   = 16;         // 2^16 mod 360
  localparam int SIGN_OFS  = 128;        // 2^31 mod 360
  localparam int SIGN_COMP = 232;        // 360 - 128
  localparam int WRAP_DN   = 104;        // -2^32 mod 360
  localparam int WRAP_UP   = 256;        //  2^32 mod 360

  // Color wheel
  localparam int SECTOR_DEG = 60;
  localparam int RISE_MUL   = 17;        // 255/60 = 17/4
  localparam int COL_MAX    = 255;

  // BT.601 brightness test
  localparam int LUMA_W     = 18;
  localparam int LUMA_R     = 299;
  localparam int LUMA_G     = 587;
  localparam int LUMA_B     = 114;
  localparam int DARK_LIMIT = 128000;

  typedef enum logic [2:0] {
    SEC_RED_GUP  = 3'd0,   // red full, green rising
    SEC_GRN_RDN  = 3'd1,   // green full, red falling
    SEC_GRN_BUP  = 3'd2,   // green full, blue rising
    SEC_BLU_GDN  = 3'd3,   // blue full, green falling
    SEC_BLU_RUP  = 3'd4,   // blue full, red rising
    SEC_RED_BDN  = 3'd5    // red full, blue falling
  } sector_t;

  typedef struct packed {
    logic [COL_W-1:0] red;
    logic [COL_W-1:0] green;
    logic [COL_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic hap;     // haptic enable after touch handling
    logic click;   // click pulse
    logic chg;     // position changed
  } flags_t;

  // One conditional subtract: v < 720 -> v mod 360
  function automatic logic [HUE_W-1:0] red360(input logic [HUE_W:0] v);
    logic [HUE_W:0] t;
    t = (v >= (HUE_W+1)'(HUE_MOD)) ? v - (HUE_W+1)'(HUE_MOD) : v;
    return t[HUE_W-1:0];
  endfunction

  // Offset the signed position by 2^31 and fold its bytes with 2^(8k) mod 360.
  // Result is congruent to (pos + 2^31) mod 360.
  function automatic logic [FOLD_W-1:0] pos_fold(input logic [POS_W-1:0] pos);
    logic [POS_W-1:0]  u;
    logic [FOLD_W-1:0] f;
    u = pos ^ {1'b1, {(POS_W-1){1'b0}}};
    f = FOLD_W'(u[31:24]) * FOLD_W'(FOLD_B3)
      + FOLD_W'(u[23:16]) * FOLD_W'(FOLD_B2)
      + FOLD_W'({u[15:8], 8'h00})
      + FOLD_W'(u[7:0]);
    return f;
  endfunction

  // Full-saturation, full-value color of a hue in 0..359
  function automatic rgb_t hue_color(input logic [HUE_W-1:0] hh);
    sector_t          sec;
    logic [HUE_W-1:0] base;
    logic [HUE_W-1:0] rem;
    logic [9:0]       rprod;
    logic [COL_W-1:0] rise;
    logic [COL_W-1:0] fall;
    rgb_t             c;
    if (hh < HUE_W'(SECTOR_DEG)) begin
      sec = SEC_RED_GUP;  base = '0;
    end else if (hh < HUE_W'(2*SECTOR_DEG)) begin
      sec = SEC_GRN_RDN;  base = HUE_W'(SECTOR_DEG);
    end else if (hh < HUE_W'(3*SECTOR_DEG)) begin
      sec = SEC_GRN_BUP;  base = HUE_W'(2*SECTOR_DEG);
    end else if (hh < HUE_W'(4*SECTOR_DEG)) begin
      sec = SEC_BLU_GDN;  base = HUE_W'(3*SECTOR_DEG);
    end else if (hh < HUE_W'(5*SECTOR_DEG)) begin
      sec = SEC_BLU_RUP;  base = HUE_W'(4*SECTOR_DEG);
    end else begin
      sec = SEC_RED_BDN;  base = HUE_W'(5*SECTOR_DEG);
    end
    rem   = hh - base;
    rprod = 10'(rem[5:0]) * 10'(RISE_MUL);
    rise  = rprod[9:2];
    fall  = COL_W'(COL_MAX) - rise;
    case (sec)
      SEC_RED_GUP: c = '{red: COL_W'(COL_MAX), green: rise, blue: '0};
      SEC_GRN_RDN: c = '{red: fall, green: COL_W'(COL_MAX), blue: '0};
      SEC_GRN_BUP: c = '{red: '0, green: COL_W'(COL_MAX), blue: rise};
      SEC_BLU_GDN: c = '{red: '0, green: fall, blue: COL_W'(COL_MAX)};
      SEC_BLU_RUP: c = '{red: rise, green: '0, blue: COL_W'(COL_MAX)};
      default:     c = '{red: COL_W'(COL_MAX), green: '0, blue: fall};
    endcase
    return c;
  endfunction

endpackage

FILE: hw/rtl/encoder_hue_wheel_color_unit.sv
// ----------------------------------------------------------------------------
// encoder_hue_wheel_color_unit: encoder-driven hue wheel with haptic click
// Tracks a hue from encoder polls, outputs its RGB color, a dark flag and
// click / haptic-enable status for every poll.
// ----------------------------------------------------------------------------
//  channel  | dir | word                                       | handshake
//  ---------+-----+--------------------------------------------+-----------
//  in_      | in  | position, touched, time_ms                 | tvalid/tready
//  out_     | out | hue, red, green, blue, dark, chg, click, hap| tvalid/tready
//  cfg_     | in  | register index + data (hue_step, cooldown, | valid/ready
//           |     | haptic present)                            |
//
//  One word per clock sustained while out_tready is high; nine register stages.
//  The running state (last position, wrap offset, touch, haptic) lives in one
//  stage; the modulo-360 multiply chain is split over the stages around it.
//  rst_n is synchronous, active low; config takes effect after reset at once.
//  out_tready low stalls the pipe; empty stages still take words, so in_tready
//  drops only when all nine stages hold a word.
//  cfg_ready is always high; writes are expected only while the pipe is idle.
// ----------------------------------------------------------------------------
module encoder_hue_wheel_color_unit
  import ehw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata: [31:0] position, [32] touched, [64:33] time_ms, [71:65] zero
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [71:0]           in_tdata,
  // out_tdata: [8:0] hue_deg, [16:9] red, [24:17] green, [32:25] blue,
  //   [33] is_dark_color, [34] hue_changed, [35] click_pulse,
  //   [36] haptic_enabled, [39:37] zero
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [39:0]           out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int NSTG = 9;

  // ---------------- pipeline control ----------------
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] adv;    // stage may take a new word
  logic [NSTG-1:0] ld;     // stage takes a word this cycle
  logic [NSTG-1:0] vld_nxt;

  assign adv[NSTG-1] = !vld_r[NSTG-1] || out_tready;
  assign ld[0]       = adv[0] && in_tvalid;
  assign vld_nxt[0]  = adv[0] ? in_tvalid : vld_r[0];

  for (genvar gi = 0; gi < NSTG-1; gi++) begin : g_ctl
    assign adv[gi]       = !vld_r[gi] || adv[gi+1];
    assign ld[gi+1]      = adv[gi+1] && vld_r[gi];
    assign vld_nxt[gi+1] = adv[gi+1] ? vld_r[gi] : vld_r[gi+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_tready = adv[0];

  // ---------------- configuration ----------------
  logic              cfg_fire;
  logic [STEP_W-1:0] hue_step_r;
  logic [COOL_W-1:0] cool_r;
  logic              present_r;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_step_r <= STEP_W'(HUE_STEP_RST);
      cool_r     <= COOL_W'(COOLDOWN_RST);
      present_r  <= 1'b0;
    end else if (cfg_fire) begin
      case (cfg_index)
        REG_HUE_STEP:  hue_step_r <= cfg_data[STEP_W-1:0];
        REG_COOLDOWN:  cool_r     <= cfg_data[COOL_W-1:0];
        REG_HAPTIC_EN: present_r  <= cfg_data[0];
        default: ;  // unknown index: dropped
      endcase
    end
  end

  // ---------------- stage 0: input register, byte fold ----------------
  logic [FOLD_W-1:0] s0_x_r;
  logic [POS_W-1:0]  s0_pos_r;
  logic              s0_touch_r;
  logic [TIME_W-1:0] s0_time_r;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      s0_x_r     <= pos_fold(in_tdata[31:0]);
      s0_pos_r   <= in_tdata[31:0];
      s0_touch_r <= in_tdata[32];
      s0_time_r  <= in_tdata[64:33];
    end
  end

  // ---------------- stage 1: quotient by 360 ----------------
  logic [33:0]       s1_prod;
  logic [HUE_W-1:0]  s1_q_r;
  logic [FOLD_W-1:0] s1_x_r;
  logic [POS_W-1:0]  s1_pos_r;
  logic              s1_touch_r;
  logic [TIME_W-1:0] s1_time_r;

  assign s1_prod = 34'(s0_x_r) * 34'(RECIP_M);

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      s1_q_r     <= s1_prod[RECIP_SH+HUE_W-1:RECIP_SH];
      s1_x_r     <= s0_x_r;
      s1_pos_r   <= s0_pos_r;
      s1_touch_r <= s0_touch_r;
      s1_time_r  <= s0_time_r;
    end
  end

  // ---------------- stage 2: signed position mod 360 ----------------
  logic [FOLD_W-1:0] s2_rem;
  logic [HUE_W-1:0]  s2_r9;
  logic [HUE_W-1:0]  s2_pm;
  logic [HUE_W-1:0]  s2_pm_r;
  logic [POS_W-1:0]  s2_pos_r;
  logic              s2_touch_r;
  logic [TIME_W-1:0] s2_time_r;

  assign s2_rem = s1_x_r - FOLD_W'(s1_q_r) * FOLD_W'(HUE_MOD);
  assign s2_r9  = s2_rem[HUE_W-1:0];
  // undo the 2^31 offset
  assign s2_pm  = (s2_r9 >= HUE_W'(SIGN_OFS)) ? s2_r9 - HUE_W'(SIGN_OFS)
                                              : s2_r9 + HUE_W'(SIGN_COMP);

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      s2_pm_r    <= s2_pm;
      s2_pos_r   <= s1_pos_r;
      s2_touch_r <= s1_touch_r;
      s2_time_r  <= s1_time_r;
    end
  end

  // ---------------- stage 3: running state ----------------
  // W = (sum of wrapped deltas since last rebase) mod 360.
  // The sum equals pos + 2^32*K, so W = pm + kacc with kacc tracking the
  // 2^32 wraps and the rebase offset.
  logic [POS_W-1:0]  last_pos_r;
  logic [HUE_W-1:0]  lm_r;        // last position mod 360
  logic [HUE_W-1:0]  kacc_r;
  logic [HUE_W-1:0]  base_r;      // hue at last rebase
  logic [HUE_W-1:0]  hue_store_r; // hue of the newest word
  logic              touch_dn_r;
  logic              hap_on_r;
  logic [TIME_W-1:0] last_tog_r;

  logic [POS_W:0]    s3_diff;
  logic [HUE_W:0]    s3_kadd;
  logic [HUE_W-1:0]  s3_kacc;
  logic [HUE_W-1:0]  s3_w;
  logic              s3_chg;
  logic [TIME_W-1:0] s3_elapsed;
  logic              s3_toggle;
  flags_t            s3_flags;
  logic              rebase;
  logic [HUE_W-1:0]  s3_w_r;
  flags_t            s3_flags_r;

  assign s3_diff = {s2_pos_r[POS_W-1], s2_pos_r} - {last_pos_r[POS_W-1], last_pos_r};

  always_comb begin
    case (s3_diff[POS_W:POS_W-1])
      2'b01:   s3_kadd = (HUE_W+1)'(WRAP_DN);  // above 2^31-1: wraps down
      2'b10:   s3_kadd = (HUE_W+1)'(WRAP_UP);  // below -2^31: wraps up
      default: s3_kadd = '0;
    endcase
  end

  assign s3_kacc    = red360({1'b0, kacc_r} + s3_kadd);
  assign s3_w       = red360({1'b0, s2_pm_r} + {1'b0, s3_kacc});
  assign s3_chg     = (s2_pos_r != last_pos_r);
  assign s3_elapsed = s2_time_r - last_tog_r;
  assign s3_toggle  = touch_dn_r && !s2_touch_r
                      && (s3_elapsed > TIME_W'(cool_r));

  assign s3_flags.chg   = s3_chg;
  assign s3_flags.click = s3_chg && present_r && hap_on_r;  // enable before touch
  assign s3_flags.hap   = hap_on_r ^ s3_toggle;

  // new step: restart the delta sum at the current hue
  assign rebase = cfg_fire && (cfg_index == REG_HUE_STEP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_pos_r <= '0;
      lm_r       <= '0;
      kacc_r     <= '0;
      base_r     <= '0;
      touch_dn_r <= 1'b0;
      hap_on_r   <= 1'b1;
      last_tog_r <= '0;
    end else if (rebase) begin
      kacc_r <= (lm_r == '0) ? '0 : HUE_W'(HUE_MOD) - lm_r;
      base_r <= hue_store_r;
    end else if (ld[3]) begin
      last_pos_r <= s2_pos_r;
      lm_r       <= s2_pm_r;
      kacc_r     <= s3_kacc;
      touch_dn_r <= s2_touch_r;
      hap_on_r   <= s3_flags.hap;
      if (s3_toggle) begin
        last_tog_r <= s2_time_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      s3_w_r     <= s3_w;
      s3_flags_r <= s3_flags;
    end
  end

  // ---------------- stage 4: base + W * step ----------------
  logic [SUM_W-1:0] s4_sum;
  logic [SUM_W-1:0] s4_sum_r;
  flags_t           s4_flags_r;

  assign s4_sum = SUM_W'(base_r) + SUM_W'(s3_w_r) * SUM_W'(hue_step_r);

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      s4_sum_r   <= s4_sum;
      s4_flags_r <= s3_flags_r;
    end
  end

  // ---------------- stage 5: quotient by 360 ----------------
  logic [34:0]      s5_prod;
  logic [HUE_W-1:0] s5_q_r;
  logic [SUM_W-1:0] s5_sum_r;
  flags_t           s5_flags_r;

  assign s5_prod = 35'(s4_sum_r) * 35'(RECIP_M);

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      s5_q_r     <= s5_prod[RECIP_SH+HUE_W-1:RECIP_SH];
      s5_sum_r   <= s4_sum_r;
      s5_flags_r <= s4_flags_r;
    end
  end

  // ---------------- stage 6: hue ----------------
  logic [SUM_W-1:0] s6_rem;
  logic [HUE_W-1:0] s6_hue_r;
  flags_t           s6_flags_r;

  assign s6_rem = s5_sum_r - SUM_W'(s5_q_r) * SUM_W'(HUE_MOD);

  always_ff @(posedge clk) begin
    if (ld[6]) begin
      s6_hue_r   <= s6_rem[HUE_W-1:0];
      s6_flags_r <= s5_flags_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_store_r <= '0;
    end else if (ld[6]) begin
      hue_store_r <= s6_rem[HUE_W-1:0];
    end
  end

  // ---------------- stage 7: color wheel ----------------
  logic [HUE_W-1:0] s7_hue_r;
  rgb_t             s7_rgb_r;
  flags_t           s7_flags_r;

  always_ff @(posedge clk) begin
    if (ld[7]) begin
      s7_hue_r   <= s6_hue_r;
      s7_rgb_r   <= hue_color(s6_hue_r);
      s7_flags_r <= s6_flags_r;
    end
  end

  // ---------------- stage 8: dark test, output register ----------------
  logic [LUMA_W-1:0] s8_luma;
  logic [HUE_W-1:0]  out_hue_r;
  rgb_t              out_rgb_r;
  logic              out_dark_r;
  flags_t            out_flags_r;

  assign s8_luma = LUMA_W'(s7_rgb_r.red)   * LUMA_W'(LUMA_R)
                 + LUMA_W'(s7_rgb_r.green) * LUMA_W'(LUMA_G)
                 + LUMA_W'(s7_rgb_r.blue)  * LUMA_W'(LUMA_B);

  always_ff @(posedge clk) begin
    if (ld[8]) begin
      out_hue_r   <= s7_hue_r;
      out_rgb_r   <= s7_rgb_r;
      out_dark_r  <= (s8_luma < LUMA_W'(DARK_LIMIT));
      out_flags_r <= s7_flags_r;
    end
  end

  assign out_tvalid = vld_r[NSTG-1];
  assign out_tdata  = {3'b000, out_flags_r.hap, out_flags_r.click, out_flags_r.chg,
                       out_dark_r, out_rgb_r.blue, out_rgb_r.green, out_rgb_r.red,
                       out_hue_r};

`ifndef ASSERT_OFF
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    hue_store_r < HUE_W'(HUE_MOD))
    else $error("stored hue out of range");

  a_kacc_range: assert property (@(posedge clk) disable iff (!rst_n)
    kacc_r < HUE_W'(HUE_MOD))
    else $error("wrap offset out of range");

  a_click_needs_change: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_flags_r.click || out_flags_r.chg))
    else $error("click without a position change");

  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (&vld_r))
    else $error("input blocked while a stage is empty");

  a_hap_steady: assert property (@(posedge clk) disable iff (!rst_n)
    !ld[3] |=> $stable(hap_on_r))
    else $error("haptic enable moved without a word");
`endif

endmodule
